/* sv/ffs_pkg.sv */
// Shared types, codes and helpers for the first-fit suballocator.
package ffs_pkg;

    // Field widths fixed by the interface
    localparam int SIZE_W   = 25;
    localparam int OFF_W    = 26;
    localparam int TYPE_W   = 3;
    localparam int FBLK_W   = 4;
    localparam int GRAN_W   = 17;
    localparam int STAT_W   = 2;

    // Default sizing
    localparam int DEF_NUM_BLOCKS        = 16;
    localparam int DEF_ENTRIES_PER_BLOCK = 64;
    localparam int DEF_BLOCK_BYTES       = 32'h0400_0000;
    localparam int DEF_NUM_TYPES         = 8;

    // Register reset values
    localparam logic [GRAN_W-1:0] GRAN_RESET   = 17'd1024;
    localparam logic [SIZE_W-1:0] MAXREQ_RESET = 25'h100_0000;

    // Configuration register indexes
    localparam logic REG_GRAN   = 1'b0;
    localparam logic REG_MAXREQ = 1'b1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic binfo_rd;
        logic blk_next;
        logic ent_start;
        logic rd_entry;
        logic ent_next;
        logic open_blk;
        logic ins_init;
        logic ins_rd;
        logic ins_wr;
        logic put;
        logic del_init;
        logic del_rd;
        logic del_wr;
        logic del_done;
        logic fin;
        logic [STAT_W-1:0] code;
    } ffs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_free;
        logic too_large;
        logic type_bad;
        logic free_bad;
        logic b_done;
        logic blk_ok;
        logic have_free;
        logic size_over;
        logic i_at_end;
        logic fit;
        logic match;
        logic ins_done;
        logic del_last;
        logic out_busy;
    } ffs_stat_t;

    // Smear the highest set bit downward: result is 2*msb-1 (mask of msb and below)
    function automatic logic [SIZE_W-1:0] smear(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] s;
        s = v | (v >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

endpackage

/* sv/ffs_ctrl.sv */
// Controller state machine for the first-fit suballocator.
module ffs_ctrl
    import ffs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ffs_stat_t st,
    output ffs_cmd_t  cmd
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_CHECK   = 16'h0002,
        S_BLK_RD  = 16'h0004,
        S_BLK     = 16'h0008,
        S_A_RD    = 16'h0010,
        S_A_EVAL  = 16'h0020,
        S_INS_CHK = 16'h0040,
        S_INS_WR  = 16'h0080,
        S_PUT     = 16'h0100,
        S_F_BI    = 16'h0200,
        S_F_LD    = 16'h0400,
        S_F_RD    = 16'h0800,
        S_F_EVAL  = 16'h1000,
        S_DEL_CHK = 16'h2000,
        S_DEL_WR  = 16'h4000,
        S_FIN     = 16'h8000
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.op_free)
                begin
                    if (st.free_bad)
                    begin
                        code_next  = ST_NOT_FOUND;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_F_BI;
                    end
                end
                else if (st.too_large)
                begin
                    code_next  = ST_TOO_LARGE;
                    state_next = S_FIN;
                end
                else if (st.type_bad)
                begin
                    code_next  = ST_NO_SPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_BLK_RD;
                end
            end
            S_BLK_RD:
            begin
                if (st.b_done)
                begin
                    if (st.have_free && !st.size_over)
                    begin
                        cmd.open_blk = 1'b1;
                        state_next   = S_PUT;
                    end
                    else
                    begin
                        code_next  = ST_NO_SPACE;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cmd.binfo_rd = 1'b1;
                    state_next   = S_BLK;
                end
            end
            S_BLK:
            begin
                if (st.blk_ok)
                begin
                    cmd.ent_start = 1'b1;
                    state_next    = S_A_RD;
                end
                else
                begin
                    cmd.blk_next = 1'b1;
                    state_next   = S_BLK_RD;
                end
            end
            S_A_RD:
            begin
                cmd.rd_entry = 1'b1;
                state_next   = S_A_EVAL;
            end
            S_A_EVAL:
            begin
                if (st.fit)
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = S_INS_CHK;
                end
                else if (st.i_at_end)
                begin
                    cmd.blk_next = 1'b1;
                    state_next   = S_BLK_RD;
                end
                else
                begin
                    cmd.ent_next = 1'b1;
                    state_next   = S_A_RD;
                end
            end
            S_INS_CHK:
            begin
                if (st.ins_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_INS_CHK;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                code_next  = ST_OK;
                state_next = S_FIN;
            end
            S_F_BI:
            begin
                cmd.binfo_rd = 1'b1;
                state_next   = S_F_LD;
            end
            S_F_LD:
            begin
                cmd.ent_start = 1'b1;
                state_next    = S_F_RD;
            end
            S_F_RD:
            begin
                if (st.i_at_end)
                begin
                    code_next  = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    state_next   = S_F_EVAL;
                end
            end
            S_F_EVAL:
            begin
                if (st.match)
                begin
                    cmd.del_init = 1'b1;
                    state_next   = S_DEL_CHK;
                end
                else
                begin
                    cmd.ent_next = 1'b1;
                    state_next   = S_F_RD;
                end
            end
            S_DEL_CHK:
            begin
                if (st.del_last)
                begin
                    cmd.del_done = 1'b1;
                    code_next    = ST_OK;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.del_rd = 1'b1;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
                state_next = S_DEL_CHK;
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/ffs_dpath.sv */
// Datapath: config registers, block table, entry memory, walk counters, result register.
module ffs_dpath
    import ffs_pkg::*;
#(
    parameter int NUM_BLOCKS        = DEF_NUM_BLOCKS,
    parameter int ENTRIES_PER_BLOCK = DEF_ENTRIES_PER_BLOCK,
    parameter int BLOCK_BYTES       = DEF_BLOCK_BYTES,
    parameter int NUM_TYPES         = DEF_NUM_TYPES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffs_cmd_t          cmd,
    output ffs_stat_t         st,
    input  logic              operation,
    input  logic [TYPE_W-1:0] memory_type,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [SIZE_W-1:0] alignment,
    input  logic              image_optimal,
    input  logic [FBLK_W-1:0] free_block,
    input  logic [OFF_W-1:0]  free_offset,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [STAT_W-1:0] status,
    output logic [FBLK_W-1:0] result_block,
    output logic [OFF_W-1:0]  result_offset,
    output logic              new_block
);

    localparam int OFS_W  = $clog2(BLOCK_BYTES) + 1;
    localparam int WW     = ((OFS_W > OFF_W) ? OFS_W : OFF_W) + 2;
    localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BCNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W  = $clog2(ENTRIES_PER_BLOCK + 1);
    localparam int DEPTH  = NUM_BLOCKS * ENTRIES_PER_BLOCK;
    localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W  = OFS_W + SIZE_W + 1;
    localparam int BI_W   = TYPE_W + CNT_W;

    // Configuration registers: granularity kept as a smeared mask (value minus one), maximum request as written
    logic [SIZE_W-1:0] gmask_reg;
    logic [SIZE_W-1:0] maxreq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmask_reg  <= SIZE_W'(GRAN_RESET - 17'd1);
            maxreq_reg <= MAXREQ_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRAN:   gmask_reg  <= smear(SIZE_W'(cfg_data[GRAN_W-1:0])) >> 1;
                REG_MAXREQ: maxreq_reg <= cfg_data;
                default:    maxreq_reg <= maxreq_reg;
            endcase
        end
    end

    // Captured request
    logic              op_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] amask_reg;
    logic              img_reg;
    logic [FBLK_W-1:0] fblk_reg;
    logic [OFF_W-1:0]  foff_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= operation;
            type_reg  <= memory_type;
            size_reg  <= {request_size[SIZE_W-1:1], 1'b0};
            amask_reg <= (smear(alignment) >> 1) | SIZE_W'(1);
            img_reg   <= image_optimal;
            fblk_reg  <= free_block;
            foff_reg  <= free_offset;
        end
    end

    // Walk registers
    logic [BCNT_W-1:0] b_reg;
    logic [BLK_W-1:0]  free_idx_reg;
    logic              have_free_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  cur_cnt_reg;
    logic [TYPE_W-1:0] cur_type_reg;
    logic [WW-1:0]     prev_end_reg;
    logic              prev_img_reg;
    logic [WW-1:0]     cand_reg;
    logic              new_flag_reg;
    logic [NUM_BLOCKS-1:0] in_use_reg;

    logic [BLK_W-1:0]  b_idx;
    assign b_idx = BLK_W'(b_reg);

    // Block info memory: type and entry count per block
    logic [BI_W-1:0]   binfo_mem [NUM_BLOCKS];
    logic [BI_W-1:0]   binfo_rd_reg;
    logic              binfo_we;
    logic [BI_W-1:0]   binfo_wd;

    assign binfo_we = cmd.put | cmd.del_done;
    assign binfo_wd = cmd.put ? {cur_type_reg, cur_cnt_reg + CNT_W'(1)}
                              : {cur_type_reg, cur_cnt_reg - CNT_W'(1)};

    always_ff @(posedge clk)
    begin
        if (binfo_we)
        begin
            binfo_mem[b_idx] <= binfo_wd;
        end
        if (cmd.binfo_rd)
        begin
            binfo_rd_reg <= binfo_mem[b_idx];
        end
    end

    logic [TYPE_W-1:0] bi_type;
    logic [CNT_W-1:0]  bi_cnt;
    assign bi_type = binfo_rd_reg[BI_W-1 -: TYPE_W];
    assign bi_cnt  = binfo_rd_reg[CNT_W-1:0];

    // Entry memory: {start, length, image}
    logic [ENT_W-1:0]  ent_mem [DEPTH];
    logic [ENT_W-1:0]  ent_rd_reg;
    logic [MEM_AW-1:0] base;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              rd_en;
    logic              wr_en;

    assign base    = MEM_AW'(b_idx) * MEM_AW'(ENTRIES_PER_BLOCK);
    assign rd_en   = cmd.rd_entry | cmd.ins_rd | cmd.del_rd;
    assign wr_en   = cmd.ins_wr | cmd.del_wr | cmd.put;
    assign rd_addr = cmd.ins_rd ? base + MEM_AW'(k_reg) - MEM_AW'(1)
                   : cmd.del_rd ? base + MEM_AW'(k_reg) + MEM_AW'(1)
                   : base + MEM_AW'(i_reg);
    assign wr_addr = cmd.put ? base + MEM_AW'(i_reg) : base + MEM_AW'(k_reg);
    assign wr_data = cmd.put ? {OFS_W'(cand_reg), size_reg, img_reg} : ent_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ent_rd_reg <= ent_mem[rd_addr];
        end
    end

    logic [OFS_W-1:0]  e_start;
    logic [SIZE_W-1:0] e_len;
    logic              e_img;
    assign e_start = ent_rd_reg[ENT_W-1 -: OFS_W];
    assign e_len   = ent_rd_reg[SIZE_W:1];
    assign e_img   = ent_rd_reg[0];

    // Aligned candidate start from previous end
    logic [SIZE_W-1:0] eff_mask;
    logic [WW-1:0]     cand_next;
    assign eff_mask  = (prev_img_reg != img_reg && amask_reg < gmask_reg) ? gmask_reg
                                                                           : amask_reg;
    assign cand_next = (prev_end_reg + WW'(eff_mask)) & ~WW'(eff_mask);

    // Gap end and fit test
    logic [WW-1:0] ns;
    logic          ni;
    logic [WW-1:0] gap_end;
    logic [WW:0]   need;
    assign ns      = (i_reg == cur_cnt_reg) ? WW'(BLOCK_BYTES) : WW'(e_start);
    assign ni      = (i_reg == cur_cnt_reg) ? img_reg : e_img;
    assign gap_end = (ni != img_reg) ? (ns & ~WW'(gmask_reg)) : ns;
    assign need    = {1'b0, cand_reg} + (WW + 1)'(size_reg);

    // Walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else if (cmd.put)
        begin
            in_use_reg[b_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            b_reg         <= (operation == OP_FREE) ? BCNT_W'(free_block) : '0;
            have_free_reg <= 1'b0;
            new_flag_reg  <= 1'b0;
        end
        if (cmd.blk_next)
        begin
            b_reg <= b_reg + BCNT_W'(1);
            if (!in_use_reg[b_idx] && !have_free_reg)
            begin
                free_idx_reg  <= b_idx;
                have_free_reg <= 1'b1;
            end
        end
        if (cmd.ent_start)
        begin
            i_reg        <= '0;
            cur_cnt_reg  <= bi_cnt;
            cur_type_reg <= bi_type;
            prev_end_reg <= '0;
            prev_img_reg <= img_reg;
        end
        if (cmd.rd_entry)
        begin
            cand_reg <= cand_next;
        end
        if (cmd.ent_next)
        begin
            i_reg        <= i_reg + CNT_W'(1);
            prev_end_reg <= WW'(e_start) + WW'(e_len);
            prev_img_reg <= e_img;
        end
        if (cmd.open_blk)
        begin
            b_reg        <= BCNT_W'(free_idx_reg);
            i_reg        <= '0;
            cur_cnt_reg  <= '0;
            cur_type_reg <= type_reg;
            cand_reg     <= '0;
            new_flag_reg <= 1'b1;
        end
        if (cmd.ins_init)
        begin
            k_reg <= cur_cnt_reg;
        end
        if (cmd.ins_wr)
        begin
            k_reg <= k_reg - CNT_W'(1);
        end
        if (cmd.del_init)
        begin
            k_reg <= i_reg;
        end
        if (cmd.del_wr)
        begin
            k_reg <= k_reg + CNT_W'(1);
        end
    end

    // Status back to the controller
    always_comb
    begin
        st           = '0;
        st.op_free   = (op_reg == OP_FREE);
        st.too_large = size_reg > maxreq_reg;
        st.type_bad  = 32'(type_reg) >= NUM_TYPES;
        st.free_bad  = (32'(fblk_reg) >= NUM_BLOCKS) || !in_use_reg[BLK_W'(fblk_reg)];
        st.b_done    = 32'(b_reg) == NUM_BLOCKS;
        st.blk_ok    = in_use_reg[b_idx] && (bi_type == type_reg)
                       && (32'(bi_cnt) < ENTRIES_PER_BLOCK);
        st.have_free = have_free_reg;
        st.size_over = 32'(size_reg) > BLOCK_BYTES;
        st.i_at_end  = (i_reg == cur_cnt_reg);
        st.fit       = need <= {1'b0, gap_end};
        st.match     = 32'(e_start) == 32'(foff_reg);
        st.ins_done  = (k_reg == i_reg);
        st.del_last  = ({1'b0, k_reg} + (CNT_W + 1)'(1)) >= {1'b0, cur_cnt_reg};
        st.out_busy  = rsp_valid & ~rsp_ready;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid <= 1'b0;
        end
        else if (cmd.fin)
        begin
            rsp_valid <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            status <= cmd.code;
            if (cmd.code == ST_OK && op_reg == OP_ALLOC)
            begin
                result_block  <= FBLK_W'(b_reg);
                result_offset <= OFF_W'(cand_reg);
                new_block     <= new_flag_reg;
            end
            else
            begin
                result_block  <= '0;
                result_offset <= '0;
                new_block     <= 1'b0;
            end
        end
    end

endmodule

/* sv/first_fit_suballocator_core.sv */
// Top level of the first-fit suballocator: controller plus datapath.
//
//  channel | handshake            | payload
//  req     | req_valid/req_ready  | operation, memory_type, request_size, alignment,
//          |                      | image_optimal, free_block, free_offset
//  rsp     | rsp_valid/rsp_ready  | status, result_block, result_offset, new_block
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// One item at a time. An allocate visits blocks and examines entries, then shifts
// entries up on insert; a free examines entries and shifts entries down. The entry
// memory has a registered read, so each entry is read and then evaluated in separate
// states. A finished beat waits in the result register while the next request is
// taken. Reset clears block usage; no clearing pass.
module first_fit_suballocator_core
    import ffs_pkg::*;
#(
    parameter int NUM_BLOCKS        = DEF_NUM_BLOCKS,
    parameter int ENTRIES_PER_BLOCK = DEF_ENTRIES_PER_BLOCK,
    parameter int BLOCK_BYTES       = DEF_BLOCK_BYTES,
    parameter int NUM_TYPES         = DEF_NUM_TYPES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              operation,
    input  logic [TYPE_W-1:0] memory_type,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [SIZE_W-1:0] alignment,
    input  logic              image_optimal,
    input  logic [FBLK_W-1:0] free_block,
    input  logic [OFF_W-1:0]  free_offset,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [STAT_W-1:0] status,
    output logic [FBLK_W-1:0] result_block,
    output logic [OFF_W-1:0]  result_offset,
    output logic              new_block,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    ffs_cmd_t  cmd;
    ffs_stat_t st;

    assign cfg_ready = 1'b1;

    ffs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ffs_dpath #(
        .NUM_BLOCKS        (NUM_BLOCKS),
        .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK),
        .BLOCK_BYTES       (BLOCK_BYTES),
        .NUM_TYPES         (NUM_TYPES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .operation     (operation),
        .memory_type   (memory_type),
        .request_size  (request_size),
        .alignment     (alignment),
        .image_optimal (image_optimal),
        .free_block    (free_block),
        .free_offset   (free_offset),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .result_block  (result_block),
        .result_offset (result_offset),
        .new_block     (new_block)
    );

endmodule

/* tb/first_fit_suballocator_core_tb.sv */
// Self-checking testbench for the first-fit suballocator core.
module first_fit_suballocator_core_tb;
    import ffs_pkg::*;

    localparam int NBLK = 16;
    localparam int NENT = 64;
    localparam longint BLK_BYTES = 64'h400_0000;
    localparam int CYCLE_LIMIT = 10_000_000;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    logic              operation;
    logic [TYPE_W-1:0] memory_type;
    logic [SIZE_W-1:0] request_size;
    logic [SIZE_W-1:0] alignment;
    logic              image_optimal;
    logic [FBLK_W-1:0] free_block;
    logic [OFF_W-1:0]  free_offset;
    logic              rsp_valid;
    logic              rsp_ready;
    logic [STAT_W-1:0] status;
    logic [FBLK_W-1:0] result_block;
    logic [OFF_W-1:0]  result_offset;
    logic              new_block;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    first_fit_suballocator_core dut (.*);

    typedef struct {
        logic              op;
        logic [TYPE_W-1:0] mtype;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] align;
        logic              img;
        logic [FBLK_W-1:0] fblk;
        logic [OFF_W-1:0]  foff;
    } alloc_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [FBLK_W-1:0] blk;
        logic [OFF_W-1:0]  off;
        logic              fresh;
    } alloc_rsp_t;

    // directed row: request plus optional typed-in answer
    typedef struct {
        alloc_req_t  rq;
        bit          fixed;
        alloc_rsp_t  ans;
    } dir_row_t;

    // shadow allocator state
    longint      gran_q;
    longint      maxreq_q;
    bit          blk_used [NBLK];
    int          blk_kind [NBLK];
    int          blk_cnt  [NBLK];
    longint      ent_start [NBLK][NENT];
    longint      ent_len   [NBLK][NENT];
    bit          ent_img   [NBLK][NENT];

    alloc_rsp_t  pending_rsp [$];
    bit          failed;
    int          cycles;
    int          rsp_seen;
    // live allocations for building valid frees
    int          live_blk [$];
    longint      live_off [$];

    function automatic longint p2_floor(longint v, longint minv);
        longint p;
        p = 1;
        while (p <= (v >> 1)) p = p << 1;
        return (p < minv) ? minv : p;
    endfunction

    function automatic bit gap_fits(longint pe, bit pi, longint ns, bit ni, longint sz,
                                    bit img, longint al, output longint at);
        longint g;
        longint a;
        longint s;
        longint e;
        g = p2_floor(gran_q, 1);
        a = al;
        if (pi != img && a < g) a = g;
        s = (pe + a - 1) & ~(a - 1);
        e = ns;
        if (ni != img) e = e & ~(g - 1);
        at = s;
        return (s + sz <= e);
    endfunction

    function automatic void insert_entry(int b, int pos, longint s, longint len, bit img);
        for (int k = blk_cnt[b]; k > pos; k--) begin
            ent_start[b][k] = ent_start[b][k-1];
            ent_len[b][k]   = ent_len[b][k-1];
            ent_img[b][k]   = ent_img[b][k-1];
        end
        ent_start[b][pos] = s;
        ent_len[b][pos]   = len;
        ent_img[b][pos]   = img;
        blk_cnt[b]++;
    endfunction

    // predicted answer for one request, updating the shadow state
    function automatic alloc_rsp_t suballoc_predict(alloc_req_t rq);
        alloc_rsp_t r;
        longint sz;
        longint al;
        longint at;
        longint pe;
        longint ns;
        bit pi;
        bit ni;
        int cnt;
        r = '{ST_OK, '0, '0, 1'b0};
        if (rq.op == OP_FREE) begin
            int b;
            b = int'(rq.fblk);
            if (!blk_used[b]) begin
                r.st = ST_NOT_FOUND;
                return r;
            end
            cnt = blk_cnt[b];
            for (int i = 0; i < cnt; i++) begin
                if (ent_start[b][i] == longint'(rq.foff)) begin
                    for (int k = i; k + 1 < cnt; k++) begin
                        ent_start[b][k] = ent_start[b][k+1];
                        ent_len[b][k]   = ent_len[b][k+1];
                        ent_img[b][k]   = ent_img[b][k+1];
                    end
                    blk_cnt[b] = cnt - 1;
                    return r;
                end
            end
            r.st = ST_NOT_FOUND;
            return r;
        end
        sz = longint'(rq.size) & 64'h1FF_FFFE;
        al = p2_floor(longint'(rq.align), 2);
        if (sz > maxreq_q) begin
            r.st = ST_TOO_LARGE;
            return r;
        end
        for (int b = 0; b < NBLK; b++) begin
            cnt = blk_cnt[b];
            if (!blk_used[b] || blk_kind[b] != int'(rq.mtype) || cnt >= NENT) continue;
            pe = 0;
            pi = rq.img;
            for (int i = 0; i <= cnt; i++) begin
                ns = (i < cnt) ? ent_start[b][i] : BLK_BYTES;
                ni = (i < cnt) ? ent_img[b][i] : rq.img;
                if (gap_fits(pe, pi, ns, ni, sz, rq.img, al, at)) begin
                    insert_entry(b, i, at, sz, rq.img);
                    r.blk = FBLK_W'(b);
                    r.off = at[OFF_W-1:0];
                    return r;
                end
                if (i < cnt) begin
                    pe = ent_start[b][i] + ent_len[b][i];
                    pi = ent_img[b][i];
                end
            end
        end
        if (sz > BLK_BYTES) begin
            r.st = ST_NO_SPACE;
            return r;
        end
        for (int b = 0; b < NBLK; b++) begin
            if (!blk_used[b]) begin
                blk_used[b] = 1'b1;
                blk_kind[b] = int'(rq.mtype);
                blk_cnt[b]  = 0;
                insert_entry(b, 0, 0, sz, rq.img);
                r.blk = FBLK_W'(b);
                r.fresh = 1'b1;
                return r;
            end
        end
        r.st = ST_NO_SPACE;
        return r;
    endfunction

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("first_fit_suballocator_core_tb: errors");
            $finish;
        end
    end

    // response side: random stall per beat, compare with oldest expectation
    initial
    begin
        int stall;
        alloc_rsp_t exp_r;
        rsp_ready = 1'b0;
        rsp_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen++;
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected response beat");
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = pending_rsp.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $error("status exp %0d got %0d", exp_r.st, status);
                        failed = 1'b1;
                    end
                    if (result_block !== exp_r.blk)
                    begin
                        $error("result_block exp %0d got %0d", exp_r.blk, result_block);
                        failed = 1'b1;
                    end
                    if (result_offset !== exp_r.off)
                    begin
                        $error("result_offset exp %0h got %0h", exp_r.off, result_offset);
                        failed = 1'b1;
                    end
                    if (new_block !== exp_r.fresh)
                    begin
                        $error("new_block exp %0d got %0d", exp_r.fresh, new_block);
                        failed = 1'b1;
                    end
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                if (stall > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    rsp_ready <= 1'b1;
                end
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // valid stays high into the next beat when no idle cycles are drawn
    task automatic send_req(alloc_req_t rq);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        operation     <= rq.op;
        memory_type   <= rq.mtype;
        request_size  <= rq.size;
        alignment     <= rq.align;
        image_optimal <= rq.img;
        free_block    <= rq.fblk;
        free_offset   <= rq.foff;
        do @(posedge clk); while (!req_ready);
    endtask

    // queue the expectation and remember live allocations
    task automatic issue(alloc_req_t rq, bit fixed, alloc_rsp_t ans);
        alloc_rsp_t p;
        p = suballoc_predict(rq);
        if (fixed && p != ans)
        begin
            $error("table row disagrees with predictor");
            failed = 1'b1;
        end
        if (rq.op == OP_ALLOC && p.st == ST_OK)
        begin
            live_blk.push_back(int'(p.blk));
            live_off.push_back(longint'(p.off));
        end
        pending_rsp.push_back(p);
        send_req(rq);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRAN) gran_q = val & 17'h1FFFF;
        else maxreq_q = val;
        @(posedge clk);
    endtask

    function automatic alloc_req_t mk_alloc(int t, longint sz, longint al, bit img);
        alloc_req_t r;
        r = '{OP_ALLOC, TYPE_W'(t), SIZE_W'(sz), SIZE_W'(al), img, '0, '0};
        return r;
    endfunction

    function automatic alloc_req_t mk_free(int b, longint off);
        alloc_req_t r;
        r = '{OP_FREE, '0, '0, SIZE_W'(2), 1'b0, FBLK_W'(b), OFF_W'(off)};
        return r;
    endfunction

    // random request: mostly allocs of modest size and frees of live entries
    function automatic alloc_req_t rand_req();
        alloc_req_t r;
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 30 && live_blk.size() > 0)
        begin
            k = $urandom_range(0, live_blk.size() - 1);
            r = mk_free(live_blk[k], live_off[k]);
            live_blk.delete(k);
            live_off.delete(k);
        end
        else if (pick < 36)
            r = mk_free($urandom_range(0, 15), $urandom());
        else if (pick < 40)
            r = '{OP_ALLOC, TYPE_W'($urandom()), SIZE_W'($urandom()), SIZE_W'($urandom()),
                  1'($urandom()), FBLK_W'($urandom()), OFF_W'($urandom())};
        else
            r = mk_alloc($urandom_range(0, 3), longint'(1) << $urandom_range(1, 21)
                         | $urandom_range(0, 4095), longint'(1) << $urandom_range(0, 14),
                         1'($urandom_range(0, 1)));
        return r;
    endfunction

    initial
    begin
        dir_row_t rows [$];
        alloc_rsp_t ok0;
        failed    = 1'b0;
        cycles    = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        operation = OP_ALLOC;
        memory_type = '0;
        request_size = '0;
        alignment = 25'd2;
        image_optimal = 1'b0;
        free_block = '0;
        free_offset = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRAN;
        cfg_data  = '0;
        gran_q    = 1024;
        maxreq_q  = 25'h100_0000;
        foreach (blk_used[i])
        begin
            blk_used[i] = 1'b0;
            blk_cnt[i]  = 0;
            blk_kind[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: fixed answers where obvious, else predictor
        ok0 = '{ST_OK, '0, '0, 1'b1};
        rows.push_back('{mk_free(0, 0), 1, '{ST_NOT_FOUND, '0, '0, 1'b0}});
        rows.push_back('{mk_alloc(0, 100, 4, 0), 1, ok0});
        rows.push_back('{mk_alloc(0, 25'h1FF_FFFF, 2, 0), 1, '{ST_TOO_LARGE, '0, '0, 1'b0}});
        rows.push_back('{mk_alloc(0, 25'h100_0000, 25'h100_0000, 1), 0, ok0});
        rows.push_back('{mk_alloc(0, 7, 0, 1), 0, ok0});
        rows.push_back('{mk_alloc(0, 0, 1, 0), 0, ok0});
        rows.push_back('{mk_alloc(0, 64, 25'h1FF_FFFF, 0), 0, ok0});
        rows.push_back('{mk_alloc(0, 64, 12, 1), 0, ok0});
        rows.push_back('{mk_alloc(7, 2, 2, 0), 0, ok0});
        rows.push_back('{mk_free(0, 0), 0, ok0});
        rows.push_back('{mk_free(0, 0), 0, ok0});
        rows.push_back('{mk_free(15, 26'h3FF_FFFF), 1, '{ST_NOT_FOUND, '0, '0, 1'b0}});
        rows.push_back('{mk_free(1, 26'h3FF_FFFF), 0, ok0});
        rows.push_back('{mk_alloc(0, 100, 4, 0), 0, ok0});
        foreach (rows[i]) issue(rows[i].rq, rows[i].fixed, rows[i].ans);
        drain();

        // allocate large entries across all types, alternating the image flag
        for (int i = 0; i < 20; i++)
            issue(mk_alloc(i % 8, 25'h100_0000, 2, i[0]), 0, ok0);
        // fill one block with many small entries to reach a full block
        for (int i = 0; i < 70; i++)
            issue(mk_alloc(0, 2, 2, i[1]), 0, ok0);
        drain();

        // random phases under several register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_GRAN, 1); write_reg(REG_MAXREQ, 2); end
                1: begin write_reg(REG_GRAN, 17'h1_0000); write_reg(REG_MAXREQ, 25'h1FF_FFFF); end
                2: begin write_reg(REG_GRAN, 0); write_reg(REG_MAXREQ, 25'h4_0000); end
                3: begin write_reg(REG_GRAN, 3000); write_reg(REG_MAXREQ, 25'h10_0000); end
                default: begin write_reg(REG_GRAN, 256); write_reg(REG_MAXREQ, 25'h100_0000); end
            endcase
            for (int i = 0; i < 60; i++) issue(rand_req(), 0, ok0);
            drain();
        end

        if (!failed)
            $display("first_fit_suballocator_core_tb: clean");
        else
            $display("first_fit_suballocator_core_tb: errors");
        $finish;
    end

endmodule
